>>> hw/rtl/orlog_pkg.sv
// Shared types and constants of the overwriting ring log.
`timescale 1ns / 1ps

package orlog_pkg;

    // Widest ring the block is ever built with, and the widths that follow from it.
    localparam int MAX_DEPTH = 64;
    localparam int PTR_W     = $clog2(MAX_DEPTH);
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);

    // Field widths of the item ports.
    localparam int DATA_W  = 64;
    localparam int COUNT_W = 5;

    // Depths of the two internal queues, as log2 of the slot count.
    localparam int CMDQ_LOG = 1;
    localparam int OUTQ_LOG = 2;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_DRAIN  = 2'd1,
        ACT_DUMP   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_RUN   = 1'b1
    } cmd_kind_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

    typedef struct packed {
        action_t             action;
        logic [DATA_W-1:0]   entry_data;
    } in_item_t;

    typedef struct packed {
        logic                entry_valid;
        logic [DATA_W-1:0]   entry_out;
        logic                last_of_run;
        logic [COUNT_W-1:0]  stored_count;
        logic                is_full;
        logic                overwrote;
    } out_item_t;

    // Work handed from the front to the back: a store write or a read run.
    typedef struct packed {
        cmd_kind_t           kind;
        logic [PTR_W-1:0]    pos;
        logic [CNT_W-1:0]    run_len;
        logic [DATA_W-1:0]   data;
        logic [COUNT_W-1:0]  stored_count;
        logic                is_full;
        logic                overwrote;
    } cmd_t;

endpackage

>>> hw/rtl/orlog_fifo.sv
// Small register queue used between the front, the back and the result ports.
`timescale 1ns / 1ps

module orlog_fifo #(
    parameter type T   = logic,
    parameter int  LOG = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  T             wr_data,
    input  logic         rd_en,
    output T             rd_data,
    output logic         full,
    output logic         empty,
    output logic [LOG:0] level
);

    localparam int SLOTS = 2 ** LOG;

    T               slots [SLOTS];
    logic [LOG-1:0] wr_ptr_reg;
    logic [LOG-1:0] rd_ptr_reg;
    logic [LOG:0]   level_reg;
    logic           do_wr;
    logic           do_rd;

    // Handshake qualification and status.
    always_comb
    begin
        full    = (level_reg == (LOG + 1)'(SLOTS));
        empty   = (level_reg == '0);
        do_wr   = wr_en && !full;
        do_rd   = rd_en && !empty;
        level   = level_reg;
        rd_data = slots[rd_ptr_reg];
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + LOG'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + LOG'(1);
            end
            if (do_wr && !do_rd)
            begin
                level_reg <= level_reg + (LOG + 1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                level_reg <= level_reg - (LOG + 1)'(1);
            end
        end
    end

    // Item storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hw/rtl/orlog_front.sv
// Front part: takes items, keeps the ring bookkeeping and issues commands.
`timescale 1ns / 1ps

module orlog_front #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  orlog_pkg::in_item_t           item,
    input  logic                          cmd_full,
    output logic                          cmd_push,
    output orlog_pkg::cmd_t               cmd,
    input  logic                          cfg_we,
    input  logic [orlog_pkg::COUNT_W-1:0] cfg_data,
    output logic [$clog2(DEPTH+1)-1:0]    eff_cap
);

    import orlog_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [COUNT_W-1:0] cap_reg;
    logic [IW-1:0]      wr_idx_reg,  wr_idx_next;
    logic [IW-1:0]      old_idx_reg, old_idx_next;
    logic [CW-1:0]      held_reg,    held_next;
    logic [CW-1:0]      unread_reg,  unread_next;

    logic [CNT_W-1:0]   cap_wide;
    logic [CNT_W-1:0]   cap_clamped;
    logic               accept;
    logic               ring_full;
    logic [IW-1:0]      wr_idx_inc;
    logic [IW-1:0]      old_idx_inc;
    logic [CW-1:0]      held_app;
    logic [CW:0]        unread_inc;
    logic [CW-1:0]      unread_app;
    logic [CW-1:0]      lag;
    logic [CW:0]        start_sum;
    logic [IW-1:0]      drain_start;

    // Effective capacity: zero acts as one, anything above the built depth as the depth.
    always_comb
    begin
        cap_wide = CNT_W'(cap_reg);
        if (cap_wide == '0)
        begin
            cap_clamped = CNT_W'(1);
        end
        else if (cap_wide > CNT_W'(DEPTH))
        begin
            cap_clamped = CNT_W'(DEPTH);
        end
        else
        begin
            cap_clamped = cap_wide;
        end
        eff_cap = CW'(cap_clamped);
    end

    // Ring arithmetic shared by the actions.
    always_comb
    begin
        accept      = push && !cmd_full;
        ring_full   = (held_reg == eff_cap);
        wr_idx_inc  = ((CW'(wr_idx_reg) + CW'(1)) >= eff_cap) ? '0 : wr_idx_reg + IW'(1);
        old_idx_inc = ((CW'(old_idx_reg) + CW'(1)) >= eff_cap) ? '0 : old_idx_reg + IW'(1);
        held_app    = ring_full ? held_reg : held_reg + CW'(1);
        // The unread count saturates at the held count, so a lapped reader restarts at the oldest.
        unread_inc  = (CW + 1)'(unread_reg) + (CW + 1)'(1);
        unread_app  = (unread_inc > (CW + 1)'(held_app)) ? held_app : CW'(unread_inc);
        lag         = held_reg - unread_reg;
        start_sum   = (CW + 1)'(old_idx_reg) + (CW + 1)'(lag);
        if (start_sum >= (CW + 1)'(eff_cap))
        begin
            start_sum = start_sum - (CW + 1)'(eff_cap);
        end
        drain_start = IW'(start_sum);
    end

    // Classify the item and build the command for the back part.
    always_comb
    begin
        wr_idx_next      = wr_idx_reg;
        old_idx_next     = old_idx_reg;
        held_next        = held_reg;
        unread_next      = unread_reg;
        cmd_push         = accept;
        cmd.kind         = CMD_RUN;
        cmd.pos          = PTR_W'(old_idx_reg);
        cmd.run_len      = '0;
        cmd.data         = item.entry_data;
        cmd.stored_count = COUNT_W'(held_reg);
        cmd.is_full      = ring_full;
        cmd.overwrote    = 1'b0;
        unique case (item.action)
            ACT_APPEND:
            begin
                wr_idx_next      = wr_idx_inc;
                old_idx_next     = ring_full ? old_idx_inc : old_idx_reg;
                held_next        = held_app;
                unread_next      = unread_app;
                cmd.kind         = CMD_WRITE;
                cmd.pos          = PTR_W'(wr_idx_reg);
                cmd.stored_count = COUNT_W'(held_app);
                cmd.is_full      = (held_app == eff_cap);
                cmd.overwrote    = ring_full;
            end
            ACT_DRAIN:
            begin
                unread_next = '0;
                cmd.pos     = PTR_W'(drain_start);
                cmd.run_len = CNT_W'(unread_reg);
            end
            ACT_DUMP:
            begin
                cmd.run_len = CNT_W'(held_reg);
            end
            ACT_CLEAR:
            begin
                wr_idx_next      = '0;
                old_idx_next     = '0;
                held_next        = '0;
                unread_next      = '0;
                cmd.stored_count = '0;
                cmd.is_full      = 1'b0;
            end
            default:
            begin
                cmd.kind = CMD_RUN;
            end
        endcase
    end

    // Capacity register and ring bookkeeping; a capacity write also empties the log.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= COUNT_W'(16);
            wr_idx_reg  <= '0;
            old_idx_reg <= '0;
            held_reg    <= '0;
            unread_reg  <= '0;
        end
        else if (cfg_we)
        begin
            cap_reg     <= cfg_data;
            wr_idx_reg  <= '0;
            old_idx_reg <= '0;
            held_reg    <= '0;
            unread_reg  <= '0;
        end
        else if (accept)
        begin
            wr_idx_reg  <= wr_idx_next;
            old_idx_reg <= old_idx_next;
            held_reg    <= held_next;
            unread_reg  <= unread_next;
        end
    end

endmodule

>>> hw/rtl/orlog_back.sv
// Back part: owns the entry store, performs writes and read runs, forms results.
`timescale 1ns / 1ps

module orlog_back #(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [$clog2(DEPTH+1)-1:0]      eff_cap,
    input  orlog_pkg::cmd_t                 cmd,
    input  logic                            cmd_empty,
    output logic                            cmd_pop,
    input  logic [orlog_pkg::OUTQ_LOG:0]    out_level,
    output logic                            res_push,
    output orlog_pkg::out_item_t            res
);

    import orlog_pkg::*;

    localparam int IW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int OUT_SLOTS = 2 ** OUTQ_LOG;

    logic [ENTRY_WIDTH-1:0] slot_mem [DEPTH];
    logic [ENTRY_WIDTH-1:0] rd_q;

    back_state_t        state_reg, state_next;
    logic [IW-1:0]      pos_reg,   pos_next;
    logic [CW-1:0]      rem_reg,   rem_next;
    logic [COUNT_W-1:0] run_count_reg, run_count_next;
    logic               run_full_reg,  run_full_next;

    logic               s1_valid_reg;
    out_item_t          s1_reg;

    logic               space;
    logic               mem_we;
    logic               mem_re;
    logic [IW-1:0]      mem_addr;
    logic [IW-1:0]      addr_inc;
    logic [IW-1:0]      cmd_pos;
    logic               issue;
    out_item_t          issue_item;

    // Room in the result queue for what is in flight plus one more result.
    always_comb
    begin
        space = ((OUTQ_LOG + 2)'(out_level) + (OUTQ_LOG + 2)'(s1_valid_reg))
                < (OUTQ_LOG + 2)'(OUT_SLOTS);
        cmd_pos = cmd.pos[IW-1:0];
    end

    // Sequencer: one store access and at most one result per cycle.
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        run_count_next = run_count_reg;
        run_full_next  = run_full_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = (state_reg == BK_RUN) ? pos_reg : cmd_pos;
        addr_inc       = ((CW'(mem_addr) + CW'(1)) >= eff_cap) ? '0 : mem_addr + IW'(1);
        issue          = 1'b0;
        issue_item.entry_valid  = 1'b0;
        issue_item.entry_out    = '0;
        issue_item.last_of_run  = 1'b1;
        issue_item.stored_count = cmd.stored_count;
        issue_item.is_full      = cmd.is_full;
        issue_item.overwrote    = cmd.overwrote;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty && space)
                begin
                    cmd_pop = 1'b1;
                    issue   = 1'b1;
                    if (cmd.kind == CMD_WRITE)
                    begin
                        mem_we = 1'b1;
                    end
                    else if (cmd.run_len != '0)
                    begin
                        // First entry of a run; longer runs continue in the run state.
                        mem_re                 = 1'b1;
                        issue_item.entry_valid = 1'b1;
                        issue_item.last_of_run = (cmd.run_len == CNT_W'(1));
                        pos_next               = addr_inc;
                        rem_next               = CW'(cmd.run_len) - CW'(1);
                        run_count_next         = cmd.stored_count;
                        run_full_next          = cmd.is_full;
                        if (cmd.run_len != CNT_W'(1))
                        begin
                            state_next = BK_RUN;
                        end
                    end
                end
            end
            BK_RUN:
            begin
                issue_item.stored_count = run_count_reg;
                issue_item.is_full      = run_full_reg;
                issue_item.overwrote    = 1'b0;
                if (space)
                begin
                    issue                  = 1'b1;
                    mem_re                 = 1'b1;
                    issue_item.entry_valid = 1'b1;
                    issue_item.last_of_run = (rem_reg == CW'(1));
                    pos_next               = addr_inc;
                    rem_next               = rem_reg - CW'(1);
                    if (rem_reg == CW'(1))
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
        end
    end

    // Run bookkeeping and the result stage that waits for read data.
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        rem_reg       <= rem_next;
        run_count_reg <= run_count_next;
        run_full_reg  <= run_full_next;
        if (issue)
        begin
            s1_reg <= issue_item;
        end
    end

    // Entry store: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_addr] <= cmd.data[ENTRY_WIDTH-1:0];
        end
        if (mem_re)
        begin
            rd_q <= slot_mem[mem_addr];
        end
    end

    // Results without an entry carry zero data.
    always_comb
    begin
        res_push      = s1_valid_reg;
        res           = s1_reg;
        res.entry_out = s1_reg.entry_valid ? DATA_W'(rd_q) : '0;
    end

endmodule

>>> hw/rtl/overwriting_ring_log_with_drain.sv
// The first result of an item passes the command queue, the back part's result stage and the
// result queue. Appends and clears give one result each; a drain or dump of n entries gives n
// results, or one empty one when n is zero, read in turn through the single store read port.
// The front keeps taking items while the back works, until the two-slot command queue fills.
// Reset clears the ring and queue counters and pointers, not the back part's run registers, and
// sets the capacity to 16; stored entries are undefined until written; no clearing pass is run.
`timescale 1ns / 1ps

module overwriting_ring_log_with_drain #(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  orlog_pkg::in_item_t           item,
    output logic                          empty,
    input  logic                          pop,
    output orlog_pkg::out_item_t          result,
    input  logic                          cfg_we,
    input  logic [orlog_pkg::COUNT_W-1:0] cfg_data
);

    import orlog_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic            cmd_push;
    cmd_t            cmd_in;
    cmd_t            cmd_head;
    logic            cmd_full;
    logic            cmd_empty;
    logic            cmd_pop;
    logic [CMDQ_LOG:0] cmd_level;
    logic [CW-1:0]   eff_cap;
    logic            res_push;
    out_item_t       res_item;
    logic            out_full;
    logic [OUTQ_LOG:0] out_level;

    // Front: item intake and ring bookkeeping.
    orlog_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .eff_cap  (eff_cap)
    );

    // Command queue between the front and the back.
    orlog_fifo #(
        .T   (cmd_t),
        .LOG (CMDQ_LOG)
    ) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .full    (cmd_full),
        .empty   (cmd_empty),
        .level   (cmd_level)
    );

    // Back: entry store and result sequencing.
    orlog_back #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_cap   (eff_cap),
        .cmd       (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .out_level (out_level),
        .res_push  (res_push),
        .res       (res_item)
    );

    // Result queue towards the consumer.
    orlog_fifo #(
        .T   (out_item_t),
        .LOG (OUTQ_LOG)
    ) u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_item),
        .rd_en   (pop),
        .rd_data (result),
        .full    (out_full),
        .empty   (empty),
        .level   (out_level)
    );

    // The input side stalls only on a full command queue; the result queue never overflows.
    assign full = cmd_full || (cmd_level > (CMDQ_LOG + 1)'(2 ** CMDQ_LOG)) || (out_full && 1'b0);

endmodule

>>> bench/overwriting_ring_log_with_drain_tb.sv
// Self-checking testbench for the overwriting ring log with drain.
`timescale 1ns / 1ps

module overwriting_ring_log_with_drain_tb;

    import orlog_pkg::*;

    localparam int LOG_DEPTH   = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 90;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    in_item_t            item = '0;
    logic                empty;
    logic                pop = 1'b0;
    out_item_t           result;
    logic                cfg_we = 1'b0;
    logic [COUNT_W-1:0]  cfg_data = '0;

    // Items waiting to be offered, and the results the log owes us, oldest first.
    in_item_t            pending_items[$];
    out_item_t           log_results_due[$];

    // Our own copy of the log state and its capacity register.
    logic [DATA_W-1:0]   log_slots[LOG_DEPTH];
    int unsigned         wr_ptr = 0;
    int unsigned         head_ptr = 0;
    int unsigned         held_n = 0;
    int unsigned         unread_n = 0;
    logic [COUNT_W-1:0]  cap_setting = 5'd16;

    int unsigned         items_taken = 0;
    int unsigned         send_gap = 0;
    int unsigned         take_gap = 0;
    int unsigned         hold_left = 0;
    int unsigned         holds_done = 0;
    int unsigned         cycle_count = 0;
    int unsigned         error_count = 0;
    logic                quiet = 1'b0;
    int unsigned         append_pct = 55;

    overwriting_ring_log_with_drain #(
        .DEPTH       (LOG_DEPTH),
        .ENTRY_WIDTH (DATA_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // Free-running clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Capacity as the log applies it: zero acts as one, anything past the depth as the depth.
    function automatic int unsigned live_capacity();
        if (cap_setting == 0)
            return 1;
        if (cap_setting > LOG_DEPTH)
            return LOG_DEPTH;
        return 32'(cap_setting);
    endfunction

    function automatic int unsigned ring_next(int unsigned idx, int unsigned cap);
        return (idx + 1 >= cap) ? 0 : idx + 1;
    endfunction

    function automatic void clear_log();
        wr_ptr   = 0;
        head_ptr = 0;
        held_n   = 0;
        unread_n = 0;
    endfunction

    function automatic void owe_result(logic valid, logic [DATA_W-1:0] data, logic last,
                                       logic over);
        out_item_t r;
        r.entry_valid  = valid;
        r.entry_out    = valid ? data : '0;
        r.last_of_run  = last;
        r.stored_count = held_n[COUNT_W-1:0];
        r.is_full      = (held_n == live_capacity());
        r.overwrote    = over;
        log_results_due = {log_results_due, r};
    endfunction

    // A drain or dump emits n entries from pos, or one empty result when n is zero.
    function automatic void owe_run(int unsigned pos, int unsigned n);
        int unsigned cap;
        cap = live_capacity();
        if (n == 0)
            owe_result(1'b0, '0, 1'b1, 1'b0);
        for (int unsigned k = 0; k < n; k++)
        begin
            owe_result(1'b1, log_slots[pos], (k + 1 == n), 1'b0);
            pos = ring_next(pos, cap);
        end
    endfunction

    // Applies one accepted item to our copy of the log and records what it must emit.
    function automatic void apply_log_action(in_item_t it);
        int unsigned cap;
        int unsigned start;
        logic        over;
        cap  = live_capacity();
        over = 1'b0;
        case (it.action)
            ACT_APPEND:
            begin
                log_slots[wr_ptr] = it.entry_data;
                wr_ptr = ring_next(wr_ptr, cap);
                if (held_n < cap)
                    held_n++;
                else
                begin
                    head_ptr = ring_next(head_ptr, cap);
                    over = 1'b1;
                end
                unread_n++;
                if (unread_n > held_n)
                    unread_n = held_n;
                owe_result(1'b0, '0, 1'b1, over);
            end
            ACT_DRAIN:
            begin
                start = head_ptr + (held_n - unread_n);
                if (start >= cap)
                    start -= cap;
                owe_run(start, unread_n);
                unread_n = 0;
            end
            ACT_DUMP:
                owe_run(head_ptr, held_n);
            default:
            begin
                clear_log();
                owe_result(1'b0, '0, 1'b1, 1'b0);
            end
        endcase
    endfunction

    // Idle stretch length: mostly none or short, now and then long.
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic void add_item(action_t act, logic [DATA_W-1:0] data);
        in_item_t it;
        it.action     = act;
        it.entry_data = data;
        pending_items = {pending_items, it};
    endfunction

    // Random item, weighted towards appends so that the ring fills and laps.
    function automatic void add_random_item();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < append_pct)
            add_item(ACT_APPEND, random_word());
        else if (r < append_pct + (100 - append_pct) / 2)
            add_item(ACT_DRAIN, random_word());
        else if (r < 96)
            add_item(ACT_DUMP, random_word());
        else
            add_item(ACT_CLEAR, random_word());
    endfunction

    // Sender: offers queued items, holding each one while the log is full.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                apply_log_action(item);
                items_taken <= items_taken + 1;
            end
            if (!push || !full)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    push     <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    item     <= pending_items.pop_front();
                    push     <= 1'b1;
                    send_gap <= idle_gap();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Receiver: checks each taken result and stalls at random, with two long holds.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            take_gap <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (log_results_due.size() == 0)
                begin
                    $display("%0t: result with none expected: valid=%0b data=%h last=%0b",
                             $time, result.entry_valid, result.entry_out, result.last_of_run);
                    error_count++;
                end
                else if (result !== log_results_due[0])
                begin
                    $display({"%0t: result mismatch: expected valid=%0b data=%h last=%0b",
                              " count=%0d full=%0b over=%0b, got valid=%0b data=%h last=%0b",
                              " count=%0d full=%0b over=%0b"}, $time,
                             log_results_due[0].entry_valid, log_results_due[0].entry_out,
                             log_results_due[0].last_of_run, log_results_due[0].stored_count,
                             log_results_due[0].is_full, log_results_due[0].overwrote,
                             result.entry_valid, result.entry_out, result.last_of_run,
                             result.stored_count, result.is_full, result.overwrote);
                    error_count++;
                    void'(log_results_due.pop_front());
                end
                else
                    void'(log_results_due.pop_front());
            end
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end
            else if (holds_done < 2 && items_taken >= 40 + holds_done * 220)
            begin
                hold_left  <= HOLD_CYCLES;
                holds_done <= holds_done + 1;
                pop        <= 1'b0;
            end
            else if (take_gap != 0)
            begin
                take_gap <= take_gap - 1;
                pop      <= 1'b0;
            end
            else
            begin
                pop      <= 1'b1;
                take_gap <= idle_gap();
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("overwriting_ring_log_with_drain regression: fail");
            $finish;
        end
    end

    // Waits until every item is taken and every result has come back.
    task automatic wait_until_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || push || log_results_due.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    // Register write while the log is idle; it also empties the log.
    task automatic write_capacity(logic [COUNT_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cap_setting = value;
        clear_log();
        @(negedge clk);
    endtask

    // Test sequence: directed cases, then random phases over several capacities.
    initial
    begin
        logic [COUNT_W-1:0] phase_caps[8];
        phase_caps = '{5'd31, 5'd0, 5'd1, 5'd7, 5'd16, 5'd3, 5'd12, 5'd5};
        phase_caps[7] = 5'($urandom_range(1, 31));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset capacity: empty drain and dump, extremes of the payload, then clear.
        add_item(ACT_DRAIN, random_word());
        add_item(ACT_DUMP, random_word());
        add_item(ACT_CLEAR, random_word());
        add_item(ACT_APPEND, '0);
        add_item(ACT_APPEND, '1);
        add_item(ACT_APPEND, {32{2'b10}});
        add_item(ACT_DUMP, '0);
        add_item(ACT_DRAIN, '1);
        add_item(ACT_DRAIN, '0);
        add_item(ACT_DUMP, random_word());
        add_item(ACT_CLEAR, '1);
        add_item(ACT_DUMP, '0);
        wait_until_idle();

        // Two slots: the writer laps the reader, so the drain restarts at the oldest entry.
        write_capacity(5'd2);
        add_item(ACT_APPEND, 64'd1);
        add_item(ACT_APPEND, 64'd2);
        add_item(ACT_APPEND, 64'd3);
        add_item(ACT_DRAIN, '0);
        add_item(ACT_APPEND, 64'd4);
        add_item(ACT_DUMP, '0);
        add_item(ACT_DRAIN, '0);
        add_item(ACT_APPEND, 64'd5);
        add_item(ACT_APPEND, 64'd6);
        add_item(ACT_APPEND, 64'd7);
        add_item(ACT_DRAIN, '0);
        wait_until_idle();

        // Random phases, alternating append-heavy and mixed, some without idling.
        for (int p = 0; p < 8; p++)
        begin
            write_capacity(phase_caps[p]);
            quiet      = (p % 3 == 1);
            append_pct = (p % 2 == 0) ? 80 : 55;
            for (int n = 0; n < 48; n++)
                add_random_item();
            wait_until_idle();
        end

        quiet = 1'b0;
        repeat (10) @(negedge clk);
        if (error_count == 0)
            $display("overwriting_ring_log_with_drain regression: pass");
        else
            $display("overwriting_ring_log_with_drain regression: fail");
        $finish;
    end

endmodule
